[hdl/pcbl_pkg.sv]
// Shared types, constants and helpers for the pulse-count backlight controller.
`default_nettype none

package pcbl_pkg;

  localparam int unsigned TableEntriesDef = 8;
  localparam int unsigned StepCountDef    = 32;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned StepW   = 6;
  localparam int unsigned PulseW  = 5;
  localparam int unsigned SizeW   = 4;
  localparam int unsigned PrevW   = 7;
  localparam int unsigned TblIdxW = 3;
  localparam int unsigned LevelsW = 64;
  localparam int unsigned StepsW  = 48;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ResW     = 18;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    ActSkip     = 2'd0,
    ActShutdown = 2'd1,
    ActAdjust   = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTableLevels  = 3'd0,
    RegTableSteps   = 3'd1,
    RegTableSize    = 3'd2,
    RegPwmPresent   = 3'd3,
    RegBootStep     = 3'd4,
    RegUpdatesEn    = 3'd5,
    RegMinBright    = 3'd6,
    RegDefaultBright = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [LevelsW-1:0] table_levels;
    logic [StepsW-1:0]  table_steps;
    logic [SizeW-1:0]   table_size;
    logic               pwm_line_present;
    logic               updates_enabled;
    logic [LevelW-1:0]  dim_threshold;
  } cfg_t;

  typedef struct packed {
    logic [PrevW-1:0]  previous_step;
    logic [LevelW-1:0] current_level;
    logic              pwm_line_high;
  } state_t;

  // Packed so that the last result field sits in the lowest bits.
  typedef struct packed {
    logic              dimming;
    logic [StepW-1:0]  target_step;
    logic              pwm_on;
    logic              pwm_off;
    logic [PulseW-1:0] pulse_count;
    logic              enable_first;
    logic              reset_first;
    action_e           action;
  } res_t;

  typedef logic [StepW-1:0] mod_lut_t [64];

  // Residues of 0..63 for a given modulus, built by counting at elaboration.
  function automatic mod_lut_t build_mod_lut(int unsigned m);
    mod_lut_t    lut;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 64; i++) begin
      lut[i] = StepW'(r);
      if (r + 1 == m) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

[hdl/pulse_count_backlight_controller.sv]
// Pulse-count backlight controller: top level with channels, registers and state.
//
// Usage: brightness requests enter on the slave stream: s_tdata_i carries the
// level and s_tuser_i the blank flag that forces brightness zero. Each item
// gives exactly one result item on the master stream, which tells the line
// driver what to do: skip, shut the line down, or reset/enable it and send a
// number of pulses, plus the PWM enable moves and the dimming flag.
// Configuration registers are written through the cfg channel (index, data),
// which is always ready; write only while no item is in flight.
// Registers: an accepted item passes the input register, then the result
// register. Throughput: one item per cycle while the receiver takes results,
// set by the combinational lookup and update of the line state in between.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that s_tready_o drops until the stall ends.
// Reset clears both stages, sets all registers to their defaults and assumes
// an unknown line step with PWM enable high.
`default_nettype none

module pulse_count_backlight_controller #(
  parameter int unsigned TABLE_ENTRIES = pcbl_pkg::TableEntriesDef,
  parameter int unsigned STEP_COUNT    = pcbl_pkg::StepCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request stream.
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [pcbl_pkg::LevelW-1:0]   s_tdata_i,   // [7:0] level
  input  wire logic                          s_tuser_i,   // [0] blank
  // Result stream.
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  // [1:0] action, [2] reset_first, [3] enable_first, [8:4] pulse_count,
  // [9] pwm_off, [10] pwm_on, [16:11] target_step, [17] dimming, [23:18] zero
  output logic [pcbl_pkg::OutDataW-1:0]      m_tdata_o,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pcbl_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [pcbl_pkg::CfgDataW-1:0] cfg_data_i
);
  import pcbl_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q, state_d, state_core;
  res_t              res_core;
  res_t              res_q;
  logic              in_valid_q;
  logic [LevelW-1:0] level_q;
  logic              blank_q;
  logic              out_valid_q;
  logic              advance;
  logic              cfg_we;

  assign advance     = !out_valid_q || m_tready_i;
  assign s_tready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pcbl_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .STEP_COUNT   (STEP_COUNT)
  ) u_core (
    .level_i(level_q),
    .blank_i(blank_q),
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .res_o  (res_core),
    .state_o(state_core)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      level_q <= s_tdata_i;
      blank_q <= s_tuser_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_core;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OutDataW-ResW)'(0), res_q};

  // Line state: updated as an item moves into the result register, or
  // loaded by the boot step and default brightness registers.
  always_comb begin
    state_d = state_q;
    if (advance && in_valid_q) begin
      state_d = state_core;
    end
    if (cfg_we && cfg_addr_i == RegBootStep) begin
      state_d.previous_step = cfg_data_i[PrevW-1:0];
    end
    if (cfg_we && cfg_addr_i == RegDefaultBright) begin
      state_d.current_level = cfg_data_i[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.previous_step <= '1;
      state_q.current_level <= '0;
      state_q.pwm_line_high <= 1'b1;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_levels     <= '0;
      cfg_q.table_steps      <= '0;
      cfg_q.table_size       <= SizeW'(1);
      cfg_q.pwm_line_present <= 1'b0;
      cfg_q.updates_enabled  <= 1'b1;
      cfg_q.dim_threshold    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr_i)
        RegTableLevels: cfg_q.table_levels     <= cfg_data_i[LevelsW-1:0];
        RegTableSteps:  cfg_q.table_steps      <= cfg_data_i[StepsW-1:0];
        RegTableSize:   cfg_q.table_size       <= cfg_data_i[SizeW-1:0];
        RegPwmPresent:  cfg_q.pwm_line_present <= cfg_data_i[0];
        RegUpdatesEn:   cfg_q.updates_enabled  <= cfg_data_i[0];
        RegMinBright:   cfg_q.dim_threshold    <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Starting from an unknown step always passes through the enable sequence.
  a_reset_implies_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && res_q.reset_first) |-> res_q.enable_first)
    else $error("reset_first without enable_first");

  a_shutdown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && res_q.action == ActShutdown) |->
      (res_q.pulse_count == '0 && !res_q.pwm_on && res_q.target_step == '0))
    else $error("shutdown result carries a step sequence");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && res_q.action == ActSkip) |->
      (!res_q.reset_first && !res_q.enable_first && res_q.pulse_count == '0 &&
       !res_q.pwm_off && !res_q.pwm_on && res_q.target_step == '0))
    else $error("skipped result carries a line action");

  a_pwm_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(res_q.pwm_on && res_q.pwm_off))
    else $error("PWM enable driven both ways");

  a_no_pwm_without_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && !cfg_q.pwm_line_present) |=>
      (!res_q.pwm_on && !res_q.pwm_off))
    else $error("PWM move with no PWM line present");
`endif

endmodule

`default_nettype wire

[hdl/pcbl_core.sv]
// Combinational decision logic: table lookup, line sequence and next state.
`default_nettype none

module pcbl_core #(
  parameter int unsigned TABLE_ENTRIES = pcbl_pkg::TableEntriesDef,
  parameter int unsigned STEP_COUNT    = pcbl_pkg::StepCountDef
) (
  input  wire logic [pcbl_pkg::LevelW-1:0] level_i,
  input  wire logic                        blank_i,
  input  wire pcbl_pkg::cfg_t              cfg_i,
  input  wire pcbl_pkg::state_t            state_i,
  output pcbl_pkg::res_t                   res_o,
  output pcbl_pkg::state_t                 state_o
);
  import pcbl_pkg::*;

  localparam mod_lut_t ModLut = build_mod_lut(STEP_COUNT);

  logic [LevelW-1:0]  bright;
  logic [SizeW-1:0]   size_c;
  logic [TblIdxW-1:0] last_idx;
  logic [LevelW-1:0]  thr [8];
  logic [StepW-1:0]   stp [8];
  logic [StepW-1:0]   tgt;
  logic               found;
  logic               skip;
  logic               prev_neg;
  logic               prev_zero;
  logic [StepW-1:0]   p_eff;
  logic [StepW-1:0]   tgt_m;
  logic [StepW-1:0]   p_m;
  logic [StepW:0]     diff;
  logic [StepW:0]     diff_m;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      thr[i] = cfg_i.table_levels[LevelW*i +: LevelW];
      stp[i] = cfg_i.table_steps[StepW*i +: StepW];
    end
  end

  assign bright = blank_i ? '0 : level_i;
  assign size_c = (cfg_i.table_size > SizeW'(TABLE_ENTRIES)) ? SizeW'(TABLE_ENTRIES)
                                                            : cfg_i.table_size;
  assign last_idx = size_c[TblIdxW-1:0] - TblIdxW'(1);
  assign skip = (!cfg_i.updates_enabled && state_i.current_level == '0) ||
                (size_c == '0);

  // First band in the descending threshold list that holds the brightness.
  always_comb begin
    found = 1'b0;
    tgt   = stp[last_idx];
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      if (!found && (SizeW'(i + 1) < size_c) && (bright <= thr[i]) &&
          (bright > thr[i+1])) begin
        found = 1'b1;
        tgt   = stp[i];
      end
    end
    if (bright == '0) begin
      tgt = '0;
    end
  end

  assign prev_neg  = state_i.previous_step[PrevW-1];
  assign prev_zero = (state_i.previous_step == '0);
  assign p_eff     = (prev_neg || prev_zero) ? StepW'(1) : state_i.previous_step[StepW-1:0];
  assign tgt_m     = ModLut[tgt];
  assign p_m       = ModLut[p_eff];
  assign diff      = {1'b0, tgt_m} + (StepW+1)'(STEP_COUNT) - {1'b0, p_m};
  assign diff_m    = (diff >= (StepW+1)'(STEP_COUNT)) ? diff - (StepW+1)'(STEP_COUNT) : diff;

  always_comb begin
    res_o   = '0;
    state_o = state_i;
    if (!skip) begin
      res_o.target_step     = tgt;
      state_o.current_level = bright;
      if (tgt == '0) begin
        res_o.action          = ActShutdown;
        res_o.pwm_off         = cfg_i.pwm_line_present;
        state_o.previous_step = '0;
        if (cfg_i.pwm_line_present) begin
          state_o.pwm_line_high = 1'b0;
        end
      end else begin
        res_o.action          = ActAdjust;
        res_o.reset_first     = prev_neg;
        res_o.enable_first    = prev_neg || prev_zero;
        res_o.pulse_count     = diff_m[PulseW-1:0];
        res_o.pwm_on          = cfg_i.pwm_line_present && !state_i.pwm_line_high;
        state_o.previous_step = {1'b0, tgt};
        if (cfg_i.pwm_line_present) begin
          state_o.pwm_line_high = 1'b1;
        end
      end
    end
    res_o.dimming = (state_o.current_level <= cfg_i.dim_threshold);
  end

endmodule

`default_nettype wire

[tb/backlight_response_checker.sv]
// Checker that predicts each backlight result from observed requests and compares it.
`timescale 1ns / 1ps

module backlight_response_checker
  import pcbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [LevelW-1:0]   req_level_i,
  input  logic                req_blank_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  results_o,
  output int                  errors_o
);

  // Register copies.
  logic [LevelsW-1:0]       thr_bank      = '0;
  logic [StepsW-1:0]        step_bank     = '0;
  logic [SizeW-1:0]         entries_used  = SizeW'(1);
  logic                     pwm_fitted    = 1'b0;
  logic                     updates_on    = 1'b1;
  logic [LevelW-1:0]        dim_floor     = '0;
  // Line state.
  logic signed [PrevW-1:0]  line_step     = '1;
  logic [LevelW-1:0]        shown_level   = '0;
  logic                     pwm_high      = 1'b1;

  res_t expected_q[$];
  int   results_seen = 0;
  int   mismatches   = 0;

  function automatic logic [StepW-1:0] step_for_level(logic [LevelW-1:0] b, int unsigned n);
    if (b == 0) return '0;
    for (int i = 0; i + 1 < n; i++) begin
      if (b <= thr_bank[8*i +: 8] && b > thr_bank[8*(i+1) +: 8]) return step_bank[6*i +: 6];
    end
    return step_bank[6*(n-1) +: 6];
  endfunction

  function automatic res_t predict_response(logic [LevelW-1:0] level, logic blank);
    res_t             r;
    logic [LevelW-1:0] b;
    int unsigned      n;
    logic [StepW-1:0] tgt;
    r = '0;
    b = blank ? '0 : level;
    n = (entries_used > TableEntriesDef) ? TableEntriesDef : entries_used;
    if (!(!updates_on && shown_level == 0) && n != 0) begin
      tgt = step_for_level(b, n);
      shown_level = b;
      r.target_step = tgt;
      if (tgt == 0) begin
        r.action  = ActShutdown;
        r.pwm_off = pwm_fitted;
        if (pwm_fitted) pwm_high = 1'b0;
        line_step = '0;
      end else begin
        r.action = ActAdjust;
        if (line_step < 0) begin
          r.reset_first = 1'b1;
          line_step = '0;
        end
        if (line_step == 0) begin
          r.enable_first = 1'b1;
          line_step = PrevW'(1);
        end
        // With 32 steps the modular distance is a plain 5-bit difference.
        r.pulse_count = tgt[PulseW-1:0] - line_step[PulseW-1:0];
        if (pwm_fitted && !pwm_high) begin
          r.pwm_on = 1'b1;
          pwm_high = 1'b1;
        end
        line_step = {1'b0, tgt};
      end
    end
    r.dimming = (shown_level <= dim_floor);
    return r;
  endfunction

  task automatic write_register(logic [CfgIdxW-1:0] addr, logic [CfgDataW-1:0] data);
    case (cfg_reg_e'(addr))
      RegTableLevels:   thr_bank = data[LevelsW-1:0];
      RegTableSteps:    step_bank = data[StepsW-1:0];
      RegTableSize:     entries_used = data[SizeW-1:0];
      RegPwmPresent:    pwm_fitted = data[0];
      RegBootStep:      line_step = data[PrevW-1:0];
      RegUpdatesEn:     updates_on = data[0];
      RegMinBright:     dim_floor = data[LevelW-1:0];
      RegDefaultBright: shown_level = data[LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      thr_bank     = '0;
      step_bank    = '0;
      entries_used = SizeW'(1);
      pwm_fitted   = 1'b0;
      updates_on   = 1'b1;
      dim_floor    = '0;
      line_step    = '1;
      shown_level  = '0;
      pwm_high     = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_addr_i, cfg_data_i);
      if (req_valid_i && req_ready_i) begin
        expected_q.push_back(predict_response(req_level_i, req_blank_i));
      end
      if (res_valid_i && res_ready_i) begin
        results_seen++;
        got = res_t'(res_data_i[ResW-1:0]);
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, res_data_i);
        end else begin
          want = expected_q.pop_front();
          check_field("action", want.action, got.action);
          check_field("reset_first", want.reset_first, got.reset_first);
          check_field("enable_first", want.enable_first, got.enable_first);
          check_field("pulse_count", want.pulse_count, got.pulse_count);
          check_field("pwm_off", want.pwm_off, got.pwm_off);
          check_field("pwm_on", want.pwm_on, got.pwm_on);
          check_field("target_step", want.target_step, got.target_step);
          check_field("dimming", want.dimming, got.dimming);
          check_field("padding", '0, res_data_i[OutDataW-1:ResW]);
        end
      end
    end
    results_o <= results_seen;
    errors_o  <= mismatches + expected_q.size();
  end

endmodule

[tb/tb.sv]
// Top of the backlight controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pcbl_pkg::*;

  typedef struct packed {
    cfg_reg_e          idx;
    logic [CfgDataW-1:0] value;
  } cfg_write_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                req_valid  = 1'b0;
  logic                req_ready;
  logic [LevelW-1:0]   req_level  = '0;
  logic                req_blank  = 1'b0;
  logic                res_valid;
  logic                res_ready  = 1'b0;
  logic [OutDataW-1:0] res_data;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  int          results_seen;
  int          errors;
  int          sent      = 0;
  int          settings  = 0;
  int unsigned gap_pct   = 20;
  logic [7:0]  thr [8];
  cfg_write_t  write_q[$];

  pulse_count_backlight_controller dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (req_valid),
    .s_tready_o (req_ready),
    .s_tdata_i  (req_level),
    .s_tuser_i  (req_blank),
    .m_tvalid_o (res_valid),
    .m_tready_i (res_ready),
    .m_tdata_o  (res_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data)
  );

  backlight_response_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_ready_i(req_ready),
    .req_level_i(req_level),
    .req_blank_i(req_blank),
    .res_valid_i(res_valid),
    .res_ready_i(res_ready),
    .res_data_i (res_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data),
    .results_o  (results_seen),
    .errors_o   (errors)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: random stall bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        stall_left = $urandom_range(0, 2);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  task automatic queue_write(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    write_q.push_back('{idx: idx, value: value});
    if (idx == RegTableLevels) begin
      for (int i = 0; i < 8; i++) thr[i] = value[8*i +: 8];
    end
  endtask

  task automatic flush_writes();
    cfg_write_t w;
    while (write_q.size() != 0) begin
      w = write_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_addr  <= w.idx;
      cfg_data  <= w.value;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic send_request(logic [LevelW-1:0] level, logic blank);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_level <= level;
    req_blank <= blank;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (results_seen != sent);
  endtask

  task automatic randomize_settings();
    logic [LevelsW-1:0] lv;
    logic [StepsW-1:0]  st;
    logic [7:0]         t;
    lv = '0;
    st = '0;
    // Mostly descending thresholds, with some entries arbitrary.
    t = 8'($urandom_range(64, 255));
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        lv[8*i +: 8] = 8'($urandom_range(0, 255));
      end else begin
        lv[8*i +: 8] = t;
      end
      t = 8'($urandom_range(0, t));
      st[6*i +: 6] = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 32));
    end
    queue_write(RegTableLevels, CfgDataW'(lv));
    queue_write(RegTableSteps, CfgDataW'(st));
    case ($urandom_range(0, 15))
      0:       queue_write(RegTableSize, 0);
      1:       queue_write(RegTableSize, CfgDataW'($urandom_range(9, 15)));
      default: queue_write(RegTableSize, CfgDataW'($urandom_range(1, 8)));
    endcase
    queue_write(RegPwmPresent, CfgDataW'($urandom_range(0, 1)));
    queue_write(RegUpdatesEn, CfgDataW'($urandom_range(0, 3) != 0));
    queue_write(RegMinBright, CfgDataW'($urandom_range(0, 255)));
    // Leave the line state alone in some phases so it carries over.
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       queue_write(RegBootStep, CfgDataW'(7'h7F));
        1:       queue_write(RegBootStep, CfgDataW'($urandom_range(0, 127)));
        default: queue_write(RegBootStep, CfgDataW'($urandom_range(0, 32)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      queue_write(RegDefaultBright,
                  CfgDataW'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int unsigned count);
    logic [LevelW-1:0] level;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 7))
        0:       level = '0;
        1, 2:    level = LevelW'(thr[$urandom_range(0, 7)] + $urandom_range(0, 1));
        default: level = LevelW'($urandom_range(0, 255));
      endcase
      send_request(level, ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: one-entry table of zeros, so every request shuts down.
    send_request(8'd0, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd128, 1'b1);
    wait_idle();

    // Full descending table with a PWM line and a step of 32 at the top.
    queue_write(RegTableLevels, 64'h01_0A_1E_3C_64_96_C8_FF);
    queue_write(RegTableSteps,
                CfgDataW'({6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd13, 6'd20, 6'd32}));
    queue_write(RegTableSize, 8);
    queue_write(RegPwmPresent, 1);
    queue_write(RegMinBright, 30);
    flush_writes();
    send_request(8'd255, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd100, 1'b0);
    send_request(8'd150, 1'b0);
    send_request(8'd200, 1'b1);
    send_request(8'd201, 1'b0);
    send_request(8'd60, 1'b0);
    send_request(8'd61, 1'b0);
    send_request(8'd11, 1'b0);
    send_request(8'hAA, 1'b0);
    send_request(8'h55, 1'b0);
    wait_idle();

    // Updates disabled: requests are skipped while the current level is zero.
    queue_write(RegUpdatesEn, 0);
    queue_write(RegDefaultBright, 0);
    flush_writes();
    send_request(8'd100, 1'b0);
    wait_idle();
    queue_write(RegDefaultBright, 5);
    flush_writes();
    send_request(8'd0, 1'b0);
    send_request(8'd77, 1'b0);
    wait_idle();

    // Empty table skips everything.
    queue_write(RegUpdatesEn, 1);
    queue_write(RegTableSize, 0);
    flush_writes();
    send_request(8'd90, 1'b0);
    wait_idle();

    // Everything at its maximum, then an unknown boot step at the negative end.
    queue_write(RegTableLevels, '1);
    queue_write(RegTableSteps, '1);
    queue_write(RegTableSize, 15);
    queue_write(RegBootStep, CfgDataW'(7'h3F));
    queue_write(RegMinBright, 255);
    queue_write(RegDefaultBright, 255);
    flush_writes();
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b0);
    send_request(8'd128, 1'b0);
    wait_idle();
    queue_write(RegBootStep, CfgDataW'(7'h40));
    flush_writes();
    send_request(8'd128, 1'b0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      if (p >= 10) gap_pct = 0;
      randomize_settings();
      flush_writes();
      random_phase(100);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d brightness requests across %0d register settings,", sent, settings);
    $display("including skips, shutdowns and step adjustments; %0d results compared.",
             results_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[pulse_count_backlight_controller.f]
hdl/pcbl_pkg.sv
hdl/pcbl_core.sv
hdl/pulse_count_backlight_controller.sv
tb/backlight_response_checker.sv
tb/tb.sv
